>>> rtl/core/plist_pkg.sv
package plist_pkg;

  // List sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int WORD_W   = 32;
  localparam int ACT_W    = 4;
  localparam int POS_W    = 6;
  localparam int ST_W     = 3;
  localparam int FIDX_W   = 4;
  localparam int LEN_W    = 5;
  localparam int MODE_W   = 2;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_APPEND     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_PREPEND    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 4'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_HEAD   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_TAIL   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DEL_AT     = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_REVERSE    = 4'd8;
  localparam logic [ACT_W-1:0] ACT_READOUT    = 4'd9;

  // Result status
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  // Cell chain moves
  //   SHR : slot at pos loads bcast, slots above take from the left
  //   SHL : slots at and above pos take from the right
  //   ROTL: slot at pos loads bcast, slots below take from the right
  localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROTL = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [WORD_W-1:0] element;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] bcast;
  } cell_cmd_t;

endpackage

>>> rtl/core/plist_cell.sv
module plist_cell (
  input  logic                                   clk,
  input  logic [plist_pkg::IDX_W-1:0]            slot,
  input  plist_pkg::cell_cmd_t                   cmd,
  input  logic signed [plist_pkg::WORD_W-1:0]    left,
  input  logic signed [plist_pkg::WORD_W-1:0]    right,
  output logic signed [plist_pkg::WORD_W-1:0]    data,
  output logic                                   match
);
  import plist_pkg::*;

  logic signed [WORD_W-1:0] data_next;

  // Select this slot's next word from the broadcast move
  always_comb begin
    data_next = data;
    case (cmd.mode)
      MODE_SHR: begin
        if (slot == cmd.pos) begin
          data_next = cmd.bcast;
        end else if (slot > cmd.pos) begin
          data_next = left;
        end
      end
      MODE_SHL: begin
        if (slot >= cmd.pos) begin
          data_next = right;
        end
      end
      MODE_ROTL: begin
        if (slot == cmd.pos) begin
          data_next = cmd.bcast;
        end else if (slot < cmd.pos) begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Payload word, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Compare against the broadcast word for search
  assign match = (data == cmd.bcast);

endmodule

>>> rtl/core/positional_list_engine.sv
// Channel  Direction  Handshake              Beat contents
// req      in         req_valid / req_ready  action, value, position
// rsp      out        rsp_valid / rsp_ready  status, found_index, element, length, last
//
// Edits, deletes and search finish in the cycle of acceptance; the result sits in
// the output register on the next cycle. Reverse does length-1 segment rotations
// of the cell chain, one per cycle, the last held while the output stalls.
// Readout gives length beats, one per chain rotation, each held while the output stalls.
// A new request is taken only when the engine is idle and the output register
// is empty or being emptied in the same cycle.
// Synchronous reset clears the element count and control; cell words are not cleared.
module positional_list_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  plist_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output plist_pkg::rsp_t   rsp
);
  import plist_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]               state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         step, step_next;
  logic                     rsp_valid_next;
  rsp_t                     rsp_next;
  cell_cmd_t                cmd;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;

  logic                     out_free, accept;
  logic                     empty, full, pos_bad;
  logic [CNT_W-1:0]         cnt_m1, cnt_m2;
  logic [IDX_W-1:0]         tail_idx, pos_at, pos_m1;
  logic signed [WORD_W-1:0] head, tail;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;

  function automatic rsp_t mk_rsp(input logic [ST_W-1:0] st, input logic [IDX_W-1:0] idx,
                                  input logic signed [WORD_W-1:0] elem,
                                  input logic [CNT_W-1:0] len, input logic lst);
    rsp_t r;
    r.status      = st;
    r.found_index = FIDX_W'(idx);
    r.element     = elem;
    r.length      = LEN_W'(len);
    r.last        = lst;
    return r;
  endfunction

  // Chain of cells, one element each, head in slot 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    plist_cell u_cell (
      .clk   (clk),
      .slot  (IDX_W'(g)),
      .cmd   (cmd),
      .left  (left_w),
      .right (right_w),
      .data  (cell_data[g]),
      .match (cell_match[g])
    );
  end

  // Derived list facts
  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign tail_idx = cnt_m1[IDX_W-1:0];
  assign head     = cell_data[0];
  assign tail     = cell_data[tail_idx];
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(CAPACITY));
  assign pos_bad  = (req.position == '0) || (int'(req.position) > int'(count));
  assign pos_at   = IDX_W'(req.position);
  assign pos_m1   = IDX_W'(req.position - POS_W'(1));

  // First live match, lowest slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  // Sequencer: decode requests, drive the chain, build result beats
  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    cmd.mode       = MODE_HOLD;
    cmd.pos        = '0;
    cmd.bcast      = req.value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_valid_next = 1'b1;
          rsp_next       = mk_rsp(ST_OK, '0, '0, count, 1'b1);
          case (req.action)
            ACT_APPEND, ACT_PREPEND: begin
              if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                cmd.mode        = MODE_SHR;
                cmd.pos         = (req.action == ACT_APPEND) ? IDX_W'(count) : '0;
                count_next      = count + CNT_W'(1);
                rsp_next.length = LEN_W'(count_next);
              end
            end
            ACT_INS_AFTER, ACT_INS_BEFORE: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else if (pos_bad) begin
                rsp_next.status = ST_BADPOS;
              end else if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                cmd.mode        = MODE_SHR;
                cmd.pos         = (req.action == ACT_INS_AFTER) ? pos_at : pos_m1;
                count_next      = count + CNT_W'(1);
                rsp_next.length = LEN_W'(count_next);
              end
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                cmd.mode        = MODE_SHL;
                cmd.pos         = (req.action == ACT_DEL_HEAD) ? '0 : tail_idx;
                count_next      = cnt_m1;
                rsp_next.length = LEN_W'(count_next);
              end
            end
            ACT_DEL_AT: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else if (pos_bad) begin
                rsp_next.status = ST_BADPOS;
              end else begin
                cmd.mode        = MODE_SHL;
                cmd.pos         = pos_m1;
                count_next      = cnt_m1;
                rsp_next.length = LEN_W'(count_next);
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else if (hit) begin
                rsp_next.found_index = FIDX_W'(hit_idx);
              end else begin
                rsp_next.status = ST_NOTFOUND;
              end
            end
            ACT_REVERSE: begin
              // Lists of fewer than two elements are already reversed
              if (count > CNT_W'(1)) begin
                rsp_valid_next = 1'b0;
                step_next      = '0;
                state_next     = S_REV;
              end
            end
            ACT_READOUT: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_valid_next = 1'b0;
                step_next      = '0;
                state_next     = S_READ;
              end
            end
            default: begin
              rsp_next.status = ST_OK;
            end
          endcase
        end
      end
      S_REV: begin
        // Rotate the segment from step to the tail right by one
        if ((CNT_W'(step) != cnt_m2) || out_free) begin
          cmd.mode  = MODE_SHR;
          cmd.pos   = step;
          cmd.bcast = tail;
          step_next = step + IDX_W'(1);
          if (CNT_W'(step) == cnt_m2) begin
            rsp_valid_next = 1'b1;
            rsp_next       = mk_rsp(ST_OK, '0, '0, count, 1'b1);
            state_next     = S_IDLE;
          end
        end
      end
      S_READ: begin
        // Show the head, then rotate the whole list left by one
        if (out_free) begin
          cmd.mode       = MODE_ROTL;
          cmd.pos        = tail_idx;
          cmd.bcast      = head;
          step_next      = step + IDX_W'(1);
          rsp_valid_next = 1'b1;
          rsp_next       = mk_rsp(ST_OK, '0, head, count, CNT_W'(step) == cnt_m1);
          if (CNT_W'(step) == cnt_m1) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.action != ACT_REVERSE && req.action != ACT_READOUT)
    |=> rsp_valid)
    else $error("single-beat request gave no result");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (state == S_READ))
    else $error("non-final beat outside readout");

  assert property (@(posedge clk) disable iff (rst)
    !(req_valid && req_ready) |=> $stable(count))
    else $error("count changed without a request");

  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cmd.mode != MODE_SHL))
    else $error("delete move issued while sequencing");

endmodule

>>> verif/positional_list_engine_test.sv
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plist_pkg::*;

  // Codes 10..15 are not actions; the engine answers them with a plain ok
  localparam logic [ACT_W-1:0] ACT_NOP = 4'd15;
  localparam int ITEM_TARGET = 320;
  localparam int CALM_FROM   = 280;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 8;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  positional_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Shadow copy of the list, head at index 0
  logic signed [WORD_W-1:0] words [CAPACITY];
  int unsigned word_count = 0;
  int unsigned longest = 0;

  rsp_t fresh_beats[$];
  rsp_t expected_beats[$];

  int mismatches = 0;
  int beats_checked = 0;
  int requests_sent = 0;
  int ignored_sent = 0;
  int status_seen[5] = '{default: 0};
  int cycles = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  int ready_hold = 0;

  typedef struct {
    req_t rq;
    bit   grow;
    bit   typed;
    rsp_t want;
  } drill_row_t;

  drill_row_t drill[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // List edits
  function automatic void open_slot(input int unsigned at, input logic signed [WORD_W-1:0] v);
    for (int unsigned i = word_count; i > at; i--) words[i] = words[i-1];
    words[at] = v;
    word_count++;
    if (word_count > longest) longest = word_count;
  endfunction

  function automatic void close_slot(input int unsigned at);
    for (int unsigned i = at; i + 1 < word_count; i++) words[i] = words[i+1];
    word_count--;
  endfunction

  // Apply one request to the shadow list and leave its beats in fresh_beats
  function automatic void predict_request(input req_t r);
    rsp_t b;
    int unsigned p;
    logic signed [WORD_W-1:0] t;
    b = '0;
    b.last = 1'b1;
    p = r.position;
    fresh_beats.delete();
    case (r.action)
      ACT_APPEND, ACT_PREPEND: begin
        if (word_count >= CAPACITY) b.status = ST_FULL;
        else open_slot((r.action == ACT_APPEND) ? word_count : 0, r.value);
      end
      ACT_INS_AFTER, ACT_INS_BEFORE: begin
        if (word_count == 0) b.status = ST_EMPTY;
        else if (p == 0 || p > word_count) b.status = ST_BADPOS;
        else if (word_count >= CAPACITY) b.status = ST_FULL;
        else open_slot((r.action == ACT_INS_AFTER) ? p : p - 1, r.value);
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL: begin
        if (word_count == 0) b.status = ST_EMPTY;
        else close_slot((r.action == ACT_DEL_HEAD) ? 0 : word_count - 1);
      end
      ACT_DEL_AT: begin
        if (word_count == 0) b.status = ST_EMPTY;
        else if (p == 0 || p > word_count) b.status = ST_BADPOS;
        else close_slot(p - 1);
      end
      ACT_SEARCH: begin
        if (word_count == 0) begin
          b.status = ST_EMPTY;
        end else begin
          b.status = ST_NOTFOUND;
          for (int unsigned i = 0; i < word_count; i++) begin
            if (b.status == ST_NOTFOUND && words[i] == r.value) begin
              b.status = ST_OK;
              b.found_index = i[FIDX_W-1:0];
            end
          end
        end
      end
      ACT_REVERSE: begin
        for (int unsigned i = 0; i < word_count / 2; i++) begin
          t = words[i];
          words[i] = words[word_count-1-i];
          words[word_count-1-i] = t;
        end
      end
      ACT_READOUT: begin
        if (word_count == 0) begin
          b.status = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < word_count; i++) begin
            b.element = words[i];
            b.length = word_count[LEN_W-1:0];
            b.last = (i + 1 == word_count);
            fresh_beats.push_back(b);
          end
          return;
        end
      end
      default: ;
    endcase
    b.length = word_count[LEN_W-1:0];
    fresh_beats.push_back(b);
  endfunction

  // Drop valid and keep the request side quiet for a while
  task automatic hold_off(input int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    hold_off(0);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Present one request, wait for its beat to be taken, then queue its results
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    int gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    predict_request(r);
    if (typed) expected_beats.push_back(want);
    else foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
    if (r.action > ACT_READOUT) ignored_sent++;
    else requests_sent++;
  endtask

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      rsp_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      ready_hold = $urandom_range(0, 10);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp.status <= ST_FULL) status_seen[rsp.status]++;
      if (expected_beats.size() == 0) begin
        flag_mismatch("beat with nothing expected", 64'(rsp), '0);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (rsp.status !== want.status)
          flag_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.found_index !== want.found_index)
          flag_mismatch("found_index", 64'(rsp.found_index), 64'(want.found_index));
        if (rsp.element !== want.element)
          flag_mismatch("element", 64'(rsp.element), 64'(want.element));
        if (rsp.length !== want.length)
          flag_mismatch("length", 64'(rsp.length), 64'(want.length));
        if (rsp.last !== want.last)
          flag_mismatch("last", 64'(rsp.last), 64'(want.last));
      end
    end
  end

  function automatic void add_row(input logic [ACT_W-1:0] act,
                                  input logic signed [WORD_W-1:0] v,
                                  input logic [POS_W-1:0] p, input bit grow,
                                  input bit typed, input logic [ST_W-1:0] st,
                                  input logic [LEN_W-1:0] len);
    drill_row_t row;
    row.rq = '{action: act, value: v, position: p};
    row.grow = grow;
    row.typed = typed;
    row.want = '{status: st, found_index: '0, element: '0, length: len, last: 1'b1};
    drill.push_back(row);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && word_count != 0) return words[$urandom_range(0, word_count - 1)];
    if (r < 5) return $signed(WORD_W'($urandom_range(0, 7))) - 4;
    if (r == 5) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return POS_W'($urandom_range(1, word_count + 1));
    if (r == 7) return '0;
    if (r == 8) return POS_W'(word_count);
    return POS_W'($urandom_range(0, 63));
  endfunction

  // mix 0 grows the list, mix 1 shrinks it, mix 2 is an even spread
  function automatic req_t random_request(input int mix);
    req_t r;
    int w;
    w = $urandom_range(0, 99);
    r.value = pick_value();
    r.position = pick_position();
    if (w >= 95) r.action = ACT_W'($urandom_range(ACT_READOUT + 1, ACT_NOP));
    else if (mix == 2) r.action = ACT_W'($urandom_range(ACT_APPEND, ACT_READOUT));
    else if (mix == 0) begin
      if (w < 25) r.action = ACT_APPEND;
      else if (w < 40) r.action = ACT_PREPEND;
      else if (w < 55) r.action = ACT_INS_AFTER;
      else if (w < 70) r.action = ACT_INS_BEFORE;
      else if (w < 80) r.action = ACT_SEARCH;
      else if (w < 85) r.action = ACT_READOUT;
      else if (w < 89) r.action = ACT_REVERSE;
      else r.action = ACT_W'($urandom_range(ACT_DEL_HEAD, ACT_DEL_AT));
    end else begin
      if (w < 15) r.action = ACT_DEL_HEAD;
      else if (w < 30) r.action = ACT_DEL_TAIL;
      else if (w < 55) r.action = ACT_DEL_AT;
      else if (w < 70) r.action = ACT_SEARCH;
      else if (w < 78) r.action = ACT_READOUT;
      else if (w < 83) r.action = ACT_REVERSE;
      else r.action = ACT_W'($urandom_range(ACT_APPEND, ACT_INS_BEFORE));
    end
    return r;
  endfunction

  initial begin
    req_t r;
    rsp_t none;
    int phase;
    int phase_len;
    int pct_pick[3];

    none = '0;
    pct_pick = '{0, 15, 35};

    // Empty list, extremes, bad positions, then a full list
    add_row(ACT_READOUT,    '0,            1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_DEL_HEAD,   '0,            1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_DEL_TAIL,   '0,            1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_DEL_AT,     '0,            1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_SEARCH,     '0,            0,  0, 1, ST_EMPTY,    0);
    add_row(ACT_INS_AFTER,  5,             1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_INS_BEFORE, 5,             1,  0, 1, ST_EMPTY,    0);
    add_row(ACT_REVERSE,    '0,            0,  0, 1, ST_OK,       0);
    add_row(ACT_NOP,        -1,            63, 0, 1, ST_OK,       0);
    add_row(ACT_APPEND,     32'sh7fffffff, 0,  0, 1, ST_OK,       1);
    add_row(ACT_PREPEND,    32'sh80000000, 63, 0, 1, ST_OK,       2);
    add_row(ACT_INS_AFTER,  1,             0,  0, 1, ST_BADPOS,   2);
    add_row(ACT_INS_BEFORE, 1,             63, 0, 1, ST_BADPOS,   2);
    add_row(ACT_DEL_AT,     '0,            0,  0, 1, ST_BADPOS,   2);
    add_row(ACT_DEL_AT,     '0,            3,  0, 1, ST_BADPOS,   2);
    add_row(ACT_INS_AFTER,  -1,            2,  0, 0, ST_OK,       0);
    add_row(ACT_INS_BEFORE, '0,            1,  0, 0, ST_OK,       0);
    add_row(ACT_SEARCH,     -1,            0,  0, 0, ST_OK,       0);
    add_row(ACT_SEARCH,     12345,         0,  0, 1, ST_NOTFOUND, 4);
    add_row(ACT_REVERSE,    '0,            0,  0, 0, ST_OK,       0);
    add_row(ACT_READOUT,    '0,            0,  0, 0, ST_OK,       0);
    add_row(ACT_DEL_AT,     '0,            2,  0, 0, ST_OK,       0);
    add_row(ACT_DEL_TAIL,   '0,            0,  0, 0, ST_OK,       0);
    add_row(ACT_APPEND,     77,            0,  1, 1, ST_FULL,     16);
    add_row(ACT_PREPEND,    77,            0,  0, 1, ST_FULL,     16);
    add_row(ACT_INS_BEFORE, 77,            16, 0, 1, ST_FULL,     16);
    add_row(ACT_INS_AFTER,  77,            17, 0, 1, ST_BADPOS,   16);
    add_row(ACT_READOUT,    '0,            0,  0, 0, ST_OK,       0);
    add_row(ACT_REVERSE,    '0,            0,  0, 0, ST_OK,       0);
    add_row(ACT_DEL_AT,     '0,            16, 0, 0, ST_OK,       0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, no idling yet
    foreach (drill[i]) begin
      if (drill[i].grow) begin
        while (word_count < CAPACITY) begin
          r = '{action: ACT_APPEND, value: pick_value(), position: pick_position()};
          send_req(r, 1'b0, none);
        end
      end
      send_req(drill[i].rq, drill[i].typed, drill[i].want);
    end
    wait_drained();

    // Random phases alternating grow, shrink and spread, with varied idling
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      phase_len = $urandom_range(20, 40);
      stall_pct = pct_pick[$urandom_range(0, 2)];
      gap_pct = pct_pick[$urandom_range(0, 2)];
      repeat (phase_len) begin
        if (requests_sent >= CALM_FROM) begin
          stall_pct = 0;
          gap_pct = 0;
        end
        send_req(random_request(phase % 3), 1'b0, none);
      end
      // let the engine empty out before the next phase now and then
      if (phase % 2 == 1 && requests_sent < CALM_FROM) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests plus %0d unused codes, %0d result beats",
             requests_sent, ignored_sent, beats_checked);
    $display("list peaked at %0d of %0d; answers seen: ok %0d, empty %0d, bad position %0d,",
             longest, CAPACITY, status_seen[0], status_seen[1], status_seen[2]);
    $display("  not found %0d, full %0d", status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
